@@ src/kst_pkg.sv @@
// Shared types and constants for the key event to scancode translator.
`timescale 1ns / 1ps
`default_nettype none

package kst_pkg;

   // Input item kinds
   localparam logic [1:0] KIND_KEY   = 2'd0;
   localparam logic [1:0] KIND_SWEEP = 2'd1;
   localparam logic [1:0] KIND_PASTE = 2'd2;

   // Result kinds
   localparam logic [1:0] OUT_SCAN    = 2'd0;
   localparam logic [1:0] OUT_FORWARD = 2'd1;
   localparam logic [1:0] OUT_PASTE   = 2'd2;

   // Virtual keys with special handling
   localparam logic [7:0] VK_CTRL      = 8'h11;
   localparam logic [7:0] VK_ALT       = 8'h12;
   localparam logic [7:0] VK_LEFT_WIN  = 8'h5B;
   localparam logic [7:0] VK_RIGHT_WIN = 8'h5C;
   localparam logic [7:0] VK_APP_MENU  = 8'h5D;
   localparam logic [7:0] VK_LETTER_V  = 8'h56;
   localparam logic [7:0] VK_IGNORED   = 8'hFF;

   // Scancode bytes
   localparam logic [7:0] CODE_EXT_PREFIX  = 8'hE0;
   localparam logic [7:0] CODE_RELEASE_BIT = 8'h80;
   localparam logic [7:0] CODE_ALT_PRESS   = 8'h38;
   localparam logic [7:0] CODE_ALT_RELEASE = 8'hB8;
   localparam logic [7:0] CODE_CTRL_UP     = 8'h9D;

   localparam logic [7:0] CHAR_NEWLINE = 8'd10;
   localparam logic [2:0] GROUP_LAST   = 3'd7;

   // Held-key table geometry: 255 slots, one spare valid bit for slot 255
   localparam int unsigned SLOT_COUNT = 255;
   localparam int unsigned SLOT_SPACE = 256;

   typedef struct packed {
      logic [1:0] kind;
      logic       hook_skip;
      logic [7:0] virtual_key;
      logic [7:0] scan_byte;
      logic       is_extended;
      logic       is_release;
      logic [2:0] sweep_group;
      logic [7:0] paste_char;
   } req_type;

   typedef struct packed {
      logic [1:0] out_kind;
      logic [7:0] scancode;
      logic       last;
   } rsp_type;

   // Work codes from front to back
   typedef enum logic [2:0] {
      OP_FORWARD,
      OP_WIN,
      OP_KEY,
      OP_SWEEP,
      OP_PASTE
   } op_type;

   typedef struct packed {
      op_type          op;
      logic [7:0]      vk;
      logic [7:0]      sc;
      logic            ext;
      logic            rel;
      logic            altgr;
      logic [2:0]      group;
      logic [2:0][7:0] pad_code;
   } cmd_type;

endpackage

`default_nettype wire

@@ src/key_event_to_scancode_translator_unit.sv @@
// Top level of the key event to scancode translator.
//
//   channel   ports                          beat moves when
//   -------   ----------------------------   ---------------------
//   input     push, full, req_payload        push && !full
//   result    empty, pop, rsp_payload        pop && !empty
//
// A key event is written into the command queue at its accepting edge, is
// then loaded into the back end, updates the table (not for forwarded
// events) and then gives its beats. A sweep is loaded, then walks its slots
// up to the last held slot (at most SWEEP_GROUP_SIZE); each held slot adds
// a registered table read and its beats. A paste is loaded, then gives
// 8 beats. Reset clears the held flags; the table itself is not cleared.
// A full result register stalls the back end; the front keeps accepting
// until the two-entry command queue is full.
`timescale 1ns / 1ps
`default_nettype none

module key_event_to_scancode_translator_unit import kst_pkg::*; #(
   parameter int unsigned SWEEP_GROUP_SIZE = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_payload,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_payload
);

   logic    queue_full;
   logic    cmd_push;
   cmd_type cmd_data;
   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd_head;

   kst_front u_front (
      .push        (push),
      .req_payload (req_payload),
      .full        (full),
      .queue_full  (queue_full),
      .cmd_push    (cmd_push),
      .cmd_data    (cmd_data)
   );

   kst_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_push   (cmd_push),
      .in_data   (cmd_data),
      .in_full   (queue_full),
      .out_valid (cmd_valid),
      .out_pop   (cmd_pop),
      .out_data  (cmd_head)
   );

   kst_back #(
      .SWEEP_GROUP_SIZE (SWEEP_GROUP_SIZE)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (cmd_valid),
      .cmd_head    (cmd_head),
      .cmd_pop     (cmd_pop),
      .empty       (empty),
      .pop         (pop),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

@@ src/kst_ram.sv @@
// Generic RAM: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module kst_ram #(
   parameter int unsigned WIDTH = 9,
   parameter int unsigned DEPTH = 255
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ src/kst_front.sv @@
// Front end: accepts input beats, classifies them and builds work commands.
`timescale 1ns / 1ps
`default_nettype none

module kst_front import kst_pkg::*; (
   input  logic    push,
   input  req_type req_payload,
   output logic    full,
   input  logic    queue_full,
   output logic    cmd_push,
   output cmd_type cmd_data
);

   // Keypad make code for one decimal digit
   function automatic logic [7:0] keypad_code(input logic [3:0] digit);
      logic [7:0] code;
      case (digit)
         4'd0:    code = 8'h52;
         4'd1:    code = 8'h4F;
         4'd2:    code = 8'h50;
         4'd3:    code = 8'h51;
         4'd4:    code = 8'h4B;
         4'd5:    code = 8'h4C;
         4'd6:    code = 8'h4D;
         4'd7:    code = 8'h47;
         4'd8:    code = 8'h48;
         4'd9:    code = 8'h49;
         default: code = 8'h52;
      endcase
      return code;
   endfunction

   logic        keep;
   logic [1:0]  hund;
   logic [7:0]  hund_sub;
   logic [6:0]  rem;
   logic [14:0] tens_prod;
   logic [3:0]  tens;
   logic [6:0]  tens_x10;
   logic [3:0]  units;

   // Decimal split of the pasted character: compare for hundreds,
   // reciprocal multiply for tens (exact below 1029)
   always_comb begin
      if (req_payload.paste_char >= 8'd200) begin
         hund     = 2'd2;
         hund_sub = 8'd200;
      end else if (req_payload.paste_char >= 8'd100) begin
         hund     = 2'd1;
         hund_sub = 8'd100;
      end else begin
         hund     = 2'd0;
         hund_sub = 8'd0;
      end
      rem       = 7'(req_payload.paste_char - hund_sub);
      tens_prod = 15'(rem) * 15'd205;
      tens      = tens_prod[14:11];
      tens_x10  = 7'(tens) * 7'd10;
      units     = 4'(rem - tens_x10);
   end

   // Classification
   always_comb begin
      keep              = 1'b1;
      cmd_data.op       = OP_KEY;
      cmd_data.vk       = req_payload.virtual_key;
      cmd_data.sc       = req_payload.scan_byte;
      cmd_data.ext      = req_payload.is_extended;
      cmd_data.rel      = req_payload.is_release;
      cmd_data.altgr    = (req_payload.virtual_key == VK_ALT) && req_payload.is_extended
                          && !req_payload.is_release;
      cmd_data.group    = req_payload.sweep_group;
      cmd_data.pad_code = {keypad_code(units), keypad_code(tens), keypad_code({2'b00, hund})};
      unique case (req_payload.kind)
         KIND_KEY: begin
            if (req_payload.hook_skip) begin
               cmd_data.op = OP_FORWARD;
            end else if (req_payload.virtual_key == VK_IGNORED) begin
               keep = 1'b0;
            end else if (req_payload.virtual_key == VK_LEFT_WIN
                         || req_payload.virtual_key == VK_RIGHT_WIN) begin
               cmd_data.op = OP_WIN;
            end else if (req_payload.virtual_key == VK_APP_MENU) begin
               cmd_data.op = OP_FORWARD;
            end
         end
         KIND_SWEEP: begin
            cmd_data.op = OP_SWEEP;
         end
         KIND_PASTE: begin
            cmd_data.op = OP_PASTE;
            if (req_payload.paste_char == CHAR_NEWLINE) begin
               keep = 1'b0;
            end
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   // Ignored keys, newline pastes and unused kinds are taken and dropped here
   assign full     = queue_full;
   assign cmd_push = push && !queue_full && keep;

endmodule

`default_nettype wire

@@ src/kst_cmd_queue.sv @@
// Two-entry command queue between front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module kst_cmd_queue import kst_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_push,
   input  cmd_type in_data,
   output logic    in_full,
   output logic    out_valid,
   input  logic    out_pop,
   output cmd_type out_data
);

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign in_full   = (count_ff == 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign do_push   = in_push && !in_full;
   assign do_pop    = out_pop && out_valid;

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

`default_nettype wire

@@ src/kst_back.sv @@
// Back end: held-key table, sequencing of scancode beats, result register.
`timescale 1ns / 1ps
`default_nettype none

module kst_back import kst_pkg::*; #(
   parameter int unsigned SWEEP_GROUP_SIZE = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   input  cmd_type cmd_head,
   output logic    cmd_pop,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_payload
);

   localparam int unsigned IdxW = (SWEEP_GROUP_SIZE > 1) ? $clog2(SWEEP_GROUP_SIZE) : 1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FWD,
      S_ALTGR,
      S_KEY,
      S_PASTEREQ,
      S_PFX,
      S_CODE,
      S_SWEEP,
      S_SRD,
      S_PASTE
   } state_type;

   state_type                   state_ff, state_in;
   cmd_type                     cmd_ff, cmd_in;
   logic                        win_held_ff, win_held_in;
   logic [SLOT_SPACE-1:0]       valid_ff, valid_in;
   logic [7:0]                  code_ff, code_in;
   logic                        code_last_ff, code_last_in;
   logic [SWEEP_GROUP_SIZE-1:0] mask_ff, mask_in;
   logic [IdxW-1:0]             idx_ff, idx_in;
   logic [7:0]                  base_ff, base_in;
   logic [2:0]                  step_ff, step_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   rsp_type                     rsp_ff, rsp_in;

   logic                        can_emit;
   logic                        emit;
   rsp_type                     emit_beat;
   logic                        valid_we, valid_set;
   logic [7:0]                  valid_addr;
   logic                        ram_we;
   logic [8:0]                  ram_rd_data;
   logic [7:0]                  slot;
   logic [SWEEP_GROUP_SIZE-1:0] mask_clear;
   logic [10:0]                 base_prod;
   logic [2:0]                  pad_pos;
   logic [7:0]                  pad_byte;

   // Held-key release codes; valid_ff says which slots are held
   kst_ram #(
      .WIDTH (9),
      .DEPTH (SLOT_COUNT)
   ) u_held_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (cmd_ff.vk),
      .wr_data ({cmd_ff.ext, cmd_ff.sc | CODE_RELEASE_BIT}),
      .rd_addr (slot),
      .rd_data (ram_rd_data)
   );

   assign can_emit   = !rsp_valid_ff || pop;
   assign slot       = base_ff + 8'(idx_ff);
   assign mask_clear = mask_ff & ~(SWEEP_GROUP_SIZE'(1) << idx_ff);
   assign base_prod  = {8'b0, cmd_head.group} * 11'(SWEEP_GROUP_SIZE);

   // Paste beat: Alt down, press/release per digit, Alt up
   always_comb begin
      pad_pos = step_ff - 3'd1;
      case (pad_pos[2:1])
         2'd0:    pad_byte = cmd_ff.pad_code[0];
         2'd1:    pad_byte = cmd_ff.pad_code[1];
         default: pad_byte = cmd_ff.pad_code[2];
      endcase
      if (pad_pos[0]) begin
         pad_byte = pad_byte | CODE_RELEASE_BIT;
      end
      if (step_ff == 3'd0) begin
         pad_byte = CODE_ALT_PRESS;
      end else if (step_ff == 3'd7) begin
         pad_byte = CODE_ALT_RELEASE;
      end
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      win_held_in  = win_held_ff;
      code_in      = code_ff;
      code_last_in = code_last_ff;
      mask_in      = mask_ff;
      idx_in       = idx_ff;
      base_in      = base_ff;
      step_in      = step_ff;
      cmd_pop      = 1'b0;
      emit         = 1'b0;
      emit_beat    = '{out_kind: OUT_SCAN, scancode: 8'h00, last: 1'b0};
      valid_we     = 1'b0;
      valid_set    = 1'b0;
      valid_addr   = cmd_ff.vk;
      ram_we       = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd_head;
               unique case (cmd_head.op) inside
                  OP_FORWARD, OP_WIN: state_in = S_FWD;
                  OP_KEY:             state_in = cmd_head.altgr ? S_ALTGR : S_KEY;
                  OP_SWEEP: begin
                     base_in = base_prod[7:0];
                     mask_in = valid_ff[base_prod[7:0] +: SWEEP_GROUP_SIZE];
                     idx_in  = '0;
                     if (cmd_head.group == GROUP_LAST) begin
                        win_held_in = 1'b0;
                     end
                     state_in = S_SWEEP;
                  end
                  OP_PASTE: begin
                     step_in  = 3'd0;
                     state_in = S_PASTE;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_FWD: begin
            if (can_emit) begin
               emit      = 1'b1;
               emit_beat = '{out_kind: OUT_FORWARD, scancode: 8'h00, last: 1'b1};
               if (cmd_ff.op == OP_WIN) begin
                  win_held_in = !cmd_ff.rel;
               end
               state_in = S_IDLE;
            end
         end
         S_ALTGR: begin
            // AltGr lets go of Control first
            if (can_emit) begin
               emit       = 1'b1;
               emit_beat  = '{out_kind: OUT_SCAN, scancode: CODE_CTRL_UP, last: 1'b0};
               valid_we   = 1'b1;
               valid_addr = VK_CTRL;
               state_in   = S_KEY;
            end
         end
         S_KEY: begin
            if (cmd_ff.vk == VK_LETTER_V && !cmd_ff.rel && win_held_ff) begin
               state_in = S_PASTEREQ;
            end else if (cmd_ff.rel && !valid_ff[cmd_ff.vk]) begin
               state_in = S_IDLE;
            end else begin
               valid_we     = 1'b1;
               valid_set    = !cmd_ff.rel;
               ram_we       = !cmd_ff.rel;
               code_in      = cmd_ff.rel ? (cmd_ff.sc | CODE_RELEASE_BIT) : cmd_ff.sc;
               code_last_in = 1'b1;
               state_in     = cmd_ff.ext ? S_PFX : S_CODE;
            end
         end
         S_PASTEREQ: begin
            if (can_emit) begin
               emit      = 1'b1;
               emit_beat = '{out_kind: OUT_PASTE, scancode: 8'h00, last: 1'b1};
               state_in  = S_IDLE;
            end
         end
         S_PFX: begin
            if (can_emit) begin
               emit      = 1'b1;
               emit_beat = '{out_kind: OUT_SCAN, scancode: CODE_EXT_PREFIX, last: 1'b0};
               state_in  = S_CODE;
            end
         end
         S_CODE: begin
            if (can_emit) begin
               emit      = 1'b1;
               emit_beat = '{out_kind: OUT_SCAN, scancode: code_ff, last: code_last_ff};
               state_in  = code_last_ff ? S_IDLE : S_SWEEP;
            end
         end
         S_SWEEP: begin
            // One slot per cycle; a held slot starts a table read
            if (mask_ff == '0) begin
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + IdxW'(1);
               if (mask_ff[idx_ff]) begin
                  mask_in      = mask_clear;
                  code_last_in = (mask_clear == '0);
                  valid_we     = 1'b1;
                  valid_addr   = slot;
                  state_in     = S_SRD;
               end
            end
         end
         S_SRD: begin
            code_in  = ram_rd_data[7:0];
            state_in = ram_rd_data[8] ? S_PFX : S_CODE;
         end
         S_PASTE: begin
            if (can_emit) begin
               emit      = 1'b1;
               emit_beat = '{out_kind: OUT_SCAN, scancode: pad_byte, last: (step_ff == 3'd7)};
               step_in   = step_ff + 3'd1;
               if (step_ff == 3'd7) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Held-slot flags, one write per cycle
   always_comb begin
      valid_in = valid_ff;
      if (valid_we) begin
         valid_in[valid_addr] = valid_set;
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !pop;
      rsp_in       = rsp_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = emit_beat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         win_held_ff  <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         win_held_ff  <= win_held_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff       <= cmd_in;
      code_ff      <= code_in;
      code_last_ff <= code_last_in;
      mask_ff      <= mask_in;
      idx_ff       <= idx_in;
      base_ff      <= base_in;
      step_ff      <= step_in;
      rsp_ff       <= rsp_in;
   end

   assign empty       = !rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking bench for the key event to scancode translator top level.
`timescale 1ns / 1ps
`default_nettype none

module testbench;
   import kst_pkg::*;

   localparam int unsigned SWEEP_GROUP_SIZE = 32;
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   // Longest back-end walk (a full sweep group) with margin
   localparam int unsigned SETTLE_CYCLES = 300;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    push = 1'b0;
   logic    full;
   req_type req_payload = '0;
   logic    empty;
   logic    pop = 1'b0;
   rsp_type rsp_payload;

   // Mirror of the block state
   logic [8:0] held_code [SLOT_COUNT];
   logic       win_down;

   rsp_type expected_beats [$];
   rsp_type staged_beats [$];
   int      fail_count = 0;
   bit      no_idle = 1'b0;

   key_event_to_scancode_translator_unit #(
      .SWEEP_GROUP_SIZE(SWEEP_GROUP_SIZE)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_payload(req_payload),
      .empty      (empty),
      .pop        (pop),
      .rsp_payload(rsp_payload)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // ---------------------------------------------------------------
   // Scancode prediction
   // ---------------------------------------------------------------
   function automatic logic [7:0] keypad_code(int unsigned digit);
      case (digit)
         0: return 8'h52;
         1: return 8'h4F;
         2: return 8'h50;
         3: return 8'h51;
         4: return 8'h4B;
         5: return 8'h4C;
         6: return 8'h4D;
         7: return 8'h47;
         8: return 8'h48;
         default: return 8'h49;
      endcase
   endfunction

   function automatic void stage_beat(logic [1:0] kind, logic [7:0] code);
      rsp_type b;
      b.out_kind = kind;
      b.scancode = code;
      b.last     = 1'b0;
      staged_beats.push_back(b);
   endfunction

   // Scancode with optional extended prefix
   function automatic void stage_code(logic ext, logic [7:0] code);
      if (ext) stage_beat(OUT_SCAN, CODE_EXT_PREFIX);
      stage_beat(OUT_SCAN, code);
   endfunction

   function automatic void translate_item(req_type it);
      rsp_type     b;
      int unsigned slot;
      int unsigned c;
      logic [7:0]  pad;
      staged_beats.delete();
      case (it.kind)
         KIND_KEY: begin
            if (it.hook_skip) begin
               stage_beat(OUT_FORWARD, 8'h00);
            end else if (it.virtual_key == VK_IGNORED) begin
            end else if (it.virtual_key == VK_LEFT_WIN || it.virtual_key == VK_RIGHT_WIN) begin
               win_down = !it.is_release;
               stage_beat(OUT_FORWARD, 8'h00);
            end else if (it.virtual_key == VK_APP_MENU) begin
               stage_beat(OUT_FORWARD, 8'h00);
            end else begin
               // AltGr lets go of Control, then continues as a normal key
               if (it.virtual_key == VK_ALT && it.is_extended && !it.is_release) begin
                  stage_beat(OUT_SCAN, CODE_CTRL_UP);
                  held_code[VK_CTRL] = '0;
               end
               if (it.virtual_key == VK_LETTER_V && !it.is_release && win_down) begin
                  stage_beat(OUT_PASTE, 8'h00);
               end else if (it.is_release) begin
                  if (held_code[it.virtual_key] != '0) begin
                     held_code[it.virtual_key] = '0;
                     stage_code(it.is_extended, it.scan_byte | CODE_RELEASE_BIT);
                  end
               end else begin
                  held_code[it.virtual_key] = {it.is_extended,
                                               it.scan_byte | CODE_RELEASE_BIT};
                  stage_code(it.is_extended, it.scan_byte);
               end
            end
         end
         KIND_SWEEP: begin
            for (int unsigned i = 0; i < SWEEP_GROUP_SIZE; i++) begin
               slot = it.sweep_group * SWEEP_GROUP_SIZE + i;
               if (slot < SLOT_COUNT && held_code[slot] != '0) begin
                  stage_code(held_code[slot][8], held_code[slot][7:0]);
                  held_code[slot] = '0;
               end
            end
            if (it.sweep_group == GROUP_LAST) win_down = 1'b0;
         end
         KIND_PASTE: begin
            if (it.paste_char != CHAR_NEWLINE) begin
               c = it.paste_char;
               stage_beat(OUT_SCAN, CODE_ALT_PRESS);
               pad = keypad_code(c / 100);
               stage_beat(OUT_SCAN, pad);
               stage_beat(OUT_SCAN, pad | CODE_RELEASE_BIT);
               pad = keypad_code((c % 100) / 10);
               stage_beat(OUT_SCAN, pad);
               stage_beat(OUT_SCAN, pad | CODE_RELEASE_BIT);
               pad = keypad_code(c % 10);
               stage_beat(OUT_SCAN, pad);
               stage_beat(OUT_SCAN, pad | CODE_RELEASE_BIT);
               stage_beat(OUT_SCAN, CODE_ALT_RELEASE);
            end
         end
         default: begin
         end
      endcase
      for (int i = 0; i < staged_beats.size(); i++) begin
         b = staged_beats[i];
         b.last = (i == staged_beats.size() - 1);
         expected_beats.push_back(b);
      end
   endfunction

   // ---------------------------------------------------------------
   // Result side: random pops and field checks
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (expected_beats.size() == 0) begin
               $error("unexpected beat: out_kind %0d scancode %h last %0d",
                      rsp_payload.out_kind, rsp_payload.scancode, rsp_payload.last);
               fail_count++;
            end else begin
               want = expected_beats.pop_front();
               if (rsp_payload.out_kind !== want.out_kind) begin
                  $error("out_kind expected %0d actual %0d",
                         want.out_kind, rsp_payload.out_kind);
                  fail_count++;
               end
               if (rsp_payload.scancode !== want.scancode) begin
                  $error("scancode expected %h actual %h",
                         want.scancode, rsp_payload.scancode);
                  fail_count++;
               end
               if (rsp_payload.last !== want.last) begin
                  $error("last expected %0d actual %0d", want.last, rsp_payload.last);
                  fail_count++;
               end
            end
         end
         pop <= no_idle ? 1'b1 : ($urandom_range(99) >= 33);
      end
   end

   // ---------------------------------------------------------------
   // Input side
   // ---------------------------------------------------------------
   // Idle cycles carry junk payload with push low
   task automatic send_item(input req_type it);
      while (!no_idle && $urandom_range(99) < 33) begin
         push        <= 1'b0;
         req_payload <= req_type'($urandom);
         @(posedge clock);
      end
      push        <= 1'b1;
      req_payload <= it;
      @(posedge clock);
      while (full) @(posedge clock);
      translate_item(it);
   endtask

   // Unused fields get random content
   function automatic req_type key_item(logic [7:0] vk, logic [7:0] sc,
                                        logic ext, logic rel);
      req_type it;
      it             = req_type'($urandom);
      it.kind        = KIND_KEY;
      it.hook_skip   = 1'b0;
      it.virtual_key = vk;
      it.scan_byte   = sc;
      it.is_extended = ext;
      it.is_release  = rel;
      return it;
   endfunction

   function automatic req_type sweep_item(logic [2:0] group);
      req_type it;
      it             = req_type'($urandom);
      it.kind        = KIND_SWEEP;
      it.sweep_group = group;
      return it;
   endfunction

   function automatic req_type paste_item(logic [7:0] ch);
      req_type it;
      it            = req_type'($urandom);
      it.kind       = KIND_PASTE;
      it.paste_char = ch;
      return it;
   endfunction

   function automatic req_type rand_item();
      req_type     it;
      int unsigned pick;
      it   = req_type'($urandom);
      pick = $urandom_range(99);
      if (pick < 62) begin
         it.kind      = KIND_KEY;
         it.hook_skip = ($urandom_range(11) == 0);
         pick         = $urandom_range(99);
         if (pick < 14) begin
            case ($urandom_range(6))
               0: it.virtual_key = VK_CTRL;
               1: it.virtual_key = VK_ALT;
               2: it.virtual_key = VK_LEFT_WIN;
               3: it.virtual_key = VK_RIGHT_WIN;
               4: it.virtual_key = VK_APP_MENU;
               5: it.virtual_key = VK_LETTER_V;
               default: it.virtual_key = VK_IGNORED;
            endcase
         end else if (pick < 70) begin
            // Small key pool so that releases find held keys
            it.virtual_key = 8'h30 + 8'($urandom_range(15));
         end
      end else if (pick < 80) begin
         it.kind = KIND_SWEEP;
      end else if (pick < 97) begin
         it.kind = KIND_PASTE;
         if ($urandom_range(9) == 0) it.paste_char = CHAR_NEWLINE;
      end else begin
         it.kind = KIND_UNUSED;
      end
      return it;
   endfunction

   // Sender holds off until the result side has caught up
   task automatic wait_for_drain();
      push <= 1'b0;
      @(posedge clock);
      while (expected_beats.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------
   task automatic test_forwarded_keys();
      req_type it;
      it           = key_item(8'h41, 8'h1E, 1'b0, 1'b0);
      it.hook_skip = 1'b1;
      send_item(it);
      send_item(key_item(VK_IGNORED, 8'hFF, 1'b1, 1'b0));
      send_item(key_item(VK_APP_MENU, 8'h5D, 1'b1, 1'b0));
      send_item(key_item(VK_LEFT_WIN, 8'h5B, 1'b1, 1'b0));
      // Paste shortcut while the left key is down
      send_item(key_item(VK_LETTER_V, 8'h2F, 1'b0, 1'b0));
      send_item(key_item(VK_LEFT_WIN, 8'h5B, 1'b1, 1'b1));
      send_item(key_item(VK_RIGHT_WIN, 8'h5C, 1'b1, 1'b0));
      send_item(key_item(VK_RIGHT_WIN, 8'h5C, 1'b1, 1'b1));
   endtask

   task automatic test_normal_keys();
      send_item(key_item(8'h41, 8'h00, 1'b0, 1'b0));
      send_item(key_item(8'h41, 8'h00, 1'b0, 1'b1));
      // Release of a key that is not down
      send_item(key_item(8'h42, 8'h30, 1'b0, 1'b1));
      send_item(key_item(VK_LETTER_V, 8'h2F, 1'b0, 1'b0));
      send_item(key_item(8'hFE, 8'hFF, 1'b1, 1'b0));
      // AltGr drops Control, so the later Control release is dropped
      send_item(key_item(VK_CTRL, 8'h1D, 1'b0, 1'b0));
      send_item(key_item(VK_ALT, 8'h38, 1'b1, 1'b0));
      send_item(key_item(VK_CTRL, 8'h1D, 1'b0, 1'b1));
      send_item(key_item(VK_ALT, 8'h38, 1'b1, 1'b1));
   endtask

   task automatic test_sweep_groups();
      send_item(key_item(8'h00, 8'h01, 1'b1, 1'b0));
      send_item(sweep_item(3'd0));
      send_item(sweep_item(3'd2));
      send_item(key_item(VK_LEFT_WIN, 8'h5B, 1'b1, 1'b0));
      // Last group clears the held-down flag; V then types normally
      send_item(sweep_item(GROUP_LAST));
      send_item(key_item(VK_LETTER_V, 8'h2F, 1'b0, 1'b0));
   endtask

   task automatic test_paste_chars();
      req_type it;
      send_item(paste_item(8'd0));
      send_item(paste_item(CHAR_NEWLINE));
      send_item(paste_item(8'd255));
      it      = req_type'($urandom);
      it.kind = KIND_UNUSED;
      send_item(it);
   endtask

   task automatic test_random_traffic(input int count, input bit steady);
      no_idle = steady;
      repeat (count) send_item(rand_item());
      no_idle = 1'b0;
   endtask

   task automatic test_release_all();
      for (int g = 0; g < 8; g++) send_item(sweep_item(3'(g)));
   endtask

   initial begin
      for (int i = 0; i < SLOT_COUNT; i++) held_code[i] = '0;
      win_down = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_forwarded_keys();
      test_normal_keys();
      test_sweep_groups();
      test_paste_chars();
      test_random_traffic(125, 1'b0);
      test_random_traffic(50, 1'b1);
      wait_for_drain();
      test_random_traffic(100, 1'b0);
      test_release_all();

      push <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
